FILE: src/zph_pkg.sv
// zph_pkg: shared types and constants for the zobrist position hash block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package zph_pkg;

   // board and table geometry
   localparam int Squares     = 64;
   localparam int PieceKinds  = 12;
   localparam int KindHalf    = 6;
   localparam int CastleBits  = 4;
   localparam int PieceWords  = Squares * PieceKinds;
   localparam int AllWords    = PieceWords + Squares;
   localparam int AddrWidth   = 10;
   localparam int SquareWidth = 6;
   localparam int KeyWidth    = 64;
   localparam int MoveWidth   = 16;

   // default depth of the queue between front and back
   localparam int QueueDepthDefault = 4;

   // configuration port
   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_SIDE_KEY       = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FULLMOVE_COEFF = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HALFMOVE_COEFF = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_CASTLE_KEY_A   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_CASTLE_KEY_B   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_CASTLE_KEY_C   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_CASTLE_KEY_D   = 3'd6;

   // input mode codes
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_ABSORB = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;

   // operations that travel through the queue
   typedef enum logic [1:0] {
      OP_LOAD_PIECE = 2'd0,
      OP_LOAD_EP    = 2'd1,
      OP_ABSORB     = 2'd2,
      OP_FINISH     = 2'd3
   } cmd_op_type;

   // one queued command; addr holds the table index, or the en-passant square
   typedef struct packed {
      cmd_op_type                 op;
      logic [AddrWidth-1:0]       addr;
      logic [KeyWidth-1:0]        word;
      logic                       white_to_move;
      logic                       ep_valid;
      logic [CastleBits-1:0]      castling;
      logic [MoveWidth-1:0]       fullmove;
      logic [MoveWidth-1:0]       halfmove;
   } cmd_type;

endpackage

`default_nettype wire

FILE: src/zph_front.sv
// zph_front: decodes each input item into a queue command, drops no-op items
// depends on zph_pkg
`timescale 1ns / 1ps
`default_nettype none

module zph_front
   import zph_pkg::*;
(
   input  wire logic                   req_valid,
   input  wire logic [1:0]             req_mode,
   input  wire logic [AddrWidth-1:0]   req_table_address,
   input  wire logic [KeyWidth-1:0]    req_table_word,
   input  wire logic [SquareWidth-1:0] req_square,
   input  wire logic [2:0]             req_piece_type,
   input  wire logic                   req_piece_black,
   input  wire logic                   req_white_to_move,
   input  wire logic                   req_ep_valid,
   input  wire logic [SquareWidth-1:0] req_ep_square,
   input  wire logic [CastleBits-1:0]  req_castling,
   input  wire logic [MoveWidth-1:0]   req_fullmove,
   input  wire logic [MoveWidth-1:0]   req_halfmove,
   input  wire logic                   queue_full,
   output logic                        push,
   output cmd_type                     push_cmd
);

   logic                 keep;
   logic [AddrWidth-1:0] kind_idx;
   logic [AddrWidth-1:0] sq_base;

   // piece index: kind-1, plus six for black
   assign kind_idx = AddrWidth'(req_piece_type) - AddrWidth'(1)
                   + (req_piece_black ? AddrWidth'(KindHalf) : AddrWidth'(0));
   // square times twelve as two shifted copies
   assign sq_base  = {1'b0, req_square, 3'b000} + {2'b00, req_square, 2'b00};

   // classify the item
   always_comb begin
      keep              = 1'b0;
      push_cmd.op       = OP_FINISH;
      push_cmd.addr     = req_table_address;
      push_cmd.word     = req_table_word;
      push_cmd.white_to_move = req_white_to_move;
      push_cmd.ep_valid = req_ep_valid;
      push_cmd.castling = req_castling;
      push_cmd.fullmove = req_fullmove;
      push_cmd.halfmove = req_halfmove;
      case (req_mode)
         MODE_LOAD: begin
            if (req_table_address < AddrWidth'(PieceWords)) begin
               keep        = 1'b1;
               push_cmd.op = OP_LOAD_PIECE;
            end else if (req_table_address < AddrWidth'(AllWords)) begin
               keep          = 1'b1;
               push_cmd.op   = OP_LOAD_EP;
               push_cmd.addr = req_table_address - AddrWidth'(PieceWords);
            end
         end
         MODE_ABSORB: begin
            if (req_piece_type != 3'd0 && req_piece_type <= 3'(KindHalf)) begin
               keep          = 1'b1;
               push_cmd.op   = OP_ABSORB;
               push_cmd.addr = sq_base + kind_idx;
            end
         end
         MODE_FINISH: begin
            keep          = 1'b1;
            push_cmd.op   = OP_FINISH;
            push_cmd.addr = AddrWidth'(req_ep_square);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_valid && !queue_full && keep;

endmodule

`default_nettype wire

FILE: src/zph_queue.sv
// zph_queue: small command fifo between the decode front and the hash back
// depends on zph_pkg
`timescale 1ns / 1ps
`default_nettype none

module zph_queue
   import zph_pkg::*;
#(
   parameter int Depth = QueueDepthDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         empty,
   output cmd_type      head
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   cmd_type               slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full  = (count_ff == CntWidth'(Depth));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: src/zph_back.sv
// zph_back: key tables, configuration registers, accumulator and result register
// depends on zph_pkg
`timescale 1ns / 1ps
`default_nettype none

module zph_back
   import zph_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [KeyWidth-1:0]      csr_data,
   input  wire logic                     queue_empty,
   input  wire cmd_type                  head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [KeyWidth-1:0]           rsp_hash_value
);

   localparam int PieceIdxWidth = $clog2(PieceWords);

   // configuration registers
   logic [KeyWidth-1:0] side_key_ff;
   logic [KeyWidth-1:0] fullmove_coeff_ff;
   logic [KeyWidth-1:0] halfmove_coeff_ff;
   logic [KeyWidth-1:0] castle_key_ff [CastleBits];

   // key tables
   logic [KeyWidth-1:0] piece_mem [PieceWords];
   logic [KeyWidth-1:0] ep_mem [Squares];
   logic [KeyWidth-1:0] piece_rd_ff;
   logic [KeyWidth-1:0] ep_rd_ff;

   // stage one
   logic                s1_valid_ff;
   cmd_op_type          s1_op_ff;
   logic                s1_ep_valid_ff;
   logic [KeyWidth-1:0] s1_misc_ff, s1_misc_in;
   logic [KeyWidth-1:0] s1_prod_f_ff, s1_prod_f_in;
   logic [KeyWidth-1:0] s1_prod_h_ff, s1_prod_h_in;

   // accumulator and result
   logic [KeyWidth-1:0] acc_ff, acc_in;
   logic                out_valid_ff, out_valid_in;
   logic [KeyWidth-1:0] out_hash_ff, out_hash_in;
   logic                advance;
   logic [KeyWidth-1:0] finish_hash;

   assign csr_ready      = 1'b1;
   assign rsp_valid      = out_valid_ff;
   assign rsp_hash_value = out_hash_ff;

   // the whole back moves unless a result sits stalled in the output register
   assign advance = !(out_valid_ff && rsp_stall);
   assign pop     = advance && !queue_empty;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         side_key_ff       <= '0;
         fullmove_coeff_ff <= '0;
         halfmove_coeff_ff <= '0;
         for (int i = 0; i < CastleBits; i++) begin
            castle_key_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIDE_KEY:       side_key_ff       <= csr_data;
            CSR_FULLMOVE_COEFF: fullmove_coeff_ff <= csr_data;
            CSR_HALFMOVE_COEFF: halfmove_coeff_ff <= csr_data;
            CSR_CASTLE_KEY_A:   castle_key_ff[0]  <= csr_data;
            CSR_CASTLE_KEY_B:   castle_key_ff[1]  <= csr_data;
            CSR_CASTLE_KEY_C:   castle_key_ff[2]  <= csr_data;
            CSR_CASTLE_KEY_D:   castle_key_ff[3]  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // piece table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pop) begin
         if (head.op == OP_LOAD_PIECE) begin
            piece_mem[head.addr[PieceIdxWidth-1:0]] <= head.word;
         end
         piece_rd_ff <= piece_mem[head.addr[PieceIdxWidth-1:0]];
      end
   end

   // en-passant table
   always_ff @(posedge clock) begin
      if (pop) begin
         if (head.op == OP_LOAD_EP) begin
            ep_mem[head.addr[SquareWidth-1:0]] <= head.word;
         end
         ep_rd_ff <= ep_mem[head.addr[SquareWidth-1:0]];
      end
   end

   // finish terms taken from the queue head: products and fixed keys
   always_comb begin
      s1_prod_f_in = KeyWidth'(head.fullmove * fullmove_coeff_ff);
      s1_prod_h_in = KeyWidth'(head.halfmove * halfmove_coeff_ff);
      s1_misc_in   = head.white_to_move ? side_key_ff : '0;
      for (int b = 0; b < CastleBits; b++) begin
         if (head.castling[b]) begin
            s1_misc_in = s1_misc_in ^ castle_key_ff[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff       <= head.op;
         s1_ep_valid_ff <= head.ep_valid;
         s1_misc_ff     <= s1_misc_in;
         s1_prod_f_ff   <= s1_prod_f_in;
         s1_prod_h_ff   <= s1_prod_h_in;
      end
   end

   // accumulate or finish
   assign finish_hash = acc_ff ^ s1_misc_ff ^ s1_prod_f_ff ^ s1_prod_h_ff
                      ^ (s1_ep_valid_ff ? ep_rd_ff : '0);

   always_comb begin
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      out_hash_in  = out_hash_ff;
      if (advance) begin
         out_valid_in = 1'b0;
         if (s1_valid_ff) begin
            case (s1_op_ff)
               OP_ABSORB: begin
                  acc_in = acc_ff ^ piece_rd_ff;
               end
               OP_FINISH: begin
                  acc_in       = '0;
                  out_valid_in = 1'b1;
                  out_hash_in  = finish_hash;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_hash_ff <= out_hash_in;
   end

endmodule

`default_nettype wire

FILE: src/zobrist_position_hash.sv
// zobrist_position_hash: top level, decode front, command queue and hash back
// depends on zph_pkg, zph_front, zph_queue, zph_back
// throughput: one item per cycle, sustained while the result side does not stall
// a finish item's result passes the queue slot, the stage-one registers and the result register
// the rate is set by one registered table read and one accumulator xor per item
// reset: synchronous, clears the queue, accumulator, config registers and result valid
`timescale 1ns / 1ps
`default_nettype none

module zobrist_position_hash
   import zph_pkg::*;
#(
   parameter int QueueDepth = QueueDepthDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_mode,
   input  wire logic [AddrWidth-1:0]     req_table_address,
   input  wire logic [KeyWidth-1:0]      req_table_word,
   input  wire logic [SquareWidth-1:0]   req_square,
   input  wire logic [2:0]               req_piece_type,
   input  wire logic                     req_piece_black,
   input  wire logic                     req_white_to_move,
   input  wire logic                     req_ep_valid,
   input  wire logic [SquareWidth-1:0]   req_ep_square,
   input  wire logic [CastleBits-1:0]    req_castling,
   input  wire logic [MoveWidth-1:0]     req_fullmove,
   input  wire logic [MoveWidth-1:0]     req_halfmove,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [KeyWidth-1:0]           rsp_hash_value,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [KeyWidth-1:0]      csr_data
);

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;
   cmd_type head;

   // input side stalls only on a full queue
   assign req_stall = queue_full;

   zph_front u_front (
      .req_valid         (req_valid),
      .req_mode          (req_mode),
      .req_table_address (req_table_address),
      .req_table_word    (req_table_word),
      .req_square        (req_square),
      .req_piece_type    (req_piece_type),
      .req_piece_black   (req_piece_black),
      .req_white_to_move (req_white_to_move),
      .req_ep_valid      (req_ep_valid),
      .req_ep_square     (req_ep_square),
      .req_castling      (req_castling),
      .req_fullmove      (req_fullmove),
      .req_halfmove      (req_halfmove),
      .queue_full        (queue_full),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   zph_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head)
   );

   zph_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .queue_empty    (queue_empty),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire

FILE: src/zph_checker.sv
// zph_checker: port-level assertions for zobrist_position_hash, with its bind
// depends on zph_pkg and the top level's ports
`timescale 1ns / 1ps
`default_nettype none

module zph_checker
   import zph_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [KeyWidth-1:0] rsp_hash_value
);

   // reset leaves no result pending and the queue open
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall left after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))
      else $error("stalled result changed");

   // the queue can only fill after an item was offered
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("input stall rose with no item offered");

   // a result does not rise straight out of reset
   a_rsp_latency: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset) && !$past(reset, 2))
      else $error("result too soon after reset");

endmodule

bind zobrist_position_hash zph_checker u_zph_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hash_value (rsp_hash_value)
);

`default_nettype wire

FILE: dv/tb.sv
// tb: self-checking testbench for zobrist_position_hash
// depends on zph_pkg and the zobrist_position_hash RTL; needs no other files
`timescale 1ns / 1ps

module tb;
   import zph_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [2:0] PIECE_NONE  = 3'd0;
   localparam logic [2:0] PIECE_PAWN  = 3'd1;
   localparam logic [2:0] PIECE_KING  = 3'd6;
   localparam logic [2:0] PIECE_BAD   = 3'd7;
   localparam int CSR_COUNT    = 7;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 255;

   // key values used by the directed part
   localparam logic [KeyWidth-1:0] KEY_ONES = '1;
   localparam logic [KeyWidth-1:0] KEY_X    = 64'h0123_4567_89ab_cdef;
   localparam logic [KeyWidth-1:0] KEY_Y    = 64'hfedc_ba98_7654_3210;
   localparam logic [KeyWidth-1:0] KEY_Z    = 64'h8000_0000_0000_0001;

   typedef enum {CFG_RESET_VALUES, CFG_ALL_ONES, CFG_RANDOM, CFG_UNIT_COEFF} cfg_set_type;

   // one input item, field by field
   typedef struct packed {
      logic [1:0]             mode;
      logic [AddrWidth-1:0]   addr;
      logic [KeyWidth-1:0]    word;
      logic [SquareWidth-1:0] square;
      logic [2:0]             piece;
      logic                   black;
      logic                   white_moves;
      logic                   ep_valid;
      logic [SquareWidth-1:0] ep_square;
      logic [CastleBits-1:0]  castling;
      logic [MoveWidth-1:0]   fullmove;
      logic [MoveWidth-1:0]   halfmove;
   } pos_item_type;

   typedef struct {
      pos_item_type        item;
      bit                  typed;
      logic [KeyWidth-1:0] hash;
      cfg_set_type         cfg;
   } script_row_type;

   // clock, reset and block ports
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic [AddrWidth-1:0] req_table_address = '0;
   logic [KeyWidth-1:0] req_table_word = '0;
   logic [SquareWidth-1:0] req_square = '0;
   logic [2:0] req_piece_type = '0;
   logic req_piece_black = 1'b0;
   logic req_white_to_move = 1'b0;
   logic req_ep_valid = 1'b0;
   logic [SquareWidth-1:0] req_ep_square = '0;
   logic [CastleBits-1:0] req_castling = '0;
   logic [MoveWidth-1:0] req_fullmove = '0;
   logic [MoveWidth-1:0] req_halfmove = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [KeyWidth-1:0] rsp_hash_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [KeyWidth-1:0] csr_data = '0;

   // predicted state of the block
   logic [KeyWidth-1:0] key_table [PieceWords];
   logic [KeyWidth-1:0] ep_table [Squares];
   logic [KeyWidth-1:0] running_hash = '0;
   logic [KeyWidth-1:0] side_key_reg = '0;
   logic [KeyWidth-1:0] full_coeff = '0;
   logic [KeyWidth-1:0] half_coeff = '0;
   logic [KeyWidth-1:0] castle_key [CastleBits];
   bit piece_loaded [PieceWords];
   bit ep_loaded [Squares];
   int piece_loaded_list [$];
   int ep_loaded_list [$];

   logic [KeyWidth-1:0] pending_hashes [$];
   logic [KeyWidth-1:0] oldest_hash;
   script_row_type script [$];
   cfg_set_type current_cfg = CFG_RESET_VALUES;

   int hash_errors = 0;
   int hashes_seen = 0;
   int items_taken = 0;
   int words_loaded = 0;
   int input_stall_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int calm_items = 0;
   int calm_left = 0;
   int hold_left = 0;
   bit hold_wanted = 1'b0;
   bit hold_done = 1'b0;

   zobrist_position_hash dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_table_address (req_table_address),
      .req_table_word    (req_table_word),
      .req_square        (req_square),
      .req_piece_type    (req_piece_type),
      .req_piece_black   (req_piece_black),
      .req_white_to_move (req_white_to_move),
      .req_ep_valid      (req_ep_valid),
      .req_ep_square     (req_ep_square),
      .req_castling      (req_castling),
      .req_fullmove      (req_fullmove),
      .req_halfmove      (req_halfmove),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hash_value    (rsp_hash_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("tb failed");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [KeyWidth-1:0] want,
                                input logic [KeyWidth-1:0] got);
      $display("ERROR %s: expected %h got %h at %0t", what, want, got, $realtime);
      hash_errors++;
   endtask

   // random values with the extremes mixed in
   function automatic logic [KeyWidth-1:0] rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [MoveWidth-1:0] rand_move();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return MoveWidth'($urandom_range(1, 200));
         default: return MoveWidth'($urandom_range(65535));
      endcase
   endfunction

   function automatic pos_item_type rand_item();
      pos_item_type it;
      it.mode        = 2'($urandom_range(3));
      it.addr        = AddrWidth'($urandom);
      it.word        = rand_word();
      it.square      = SquareWidth'($urandom);
      it.piece       = 3'($urandom);
      it.black       = 1'($urandom);
      it.white_moves = 1'($urandom);
      it.ep_valid    = 1'($urandom);
      it.ep_square   = SquareWidth'($urandom);
      it.castling    = CastleBits'($urandom);
      it.fullmove    = rand_move();
      it.halfmove    = rand_move();
      return it;
   endfunction

   // item builders for the directed table
   function automatic pos_item_type load_item(input int addr, input logic [KeyWidth-1:0] word);
      pos_item_type it;
      it = '0;
      it.mode = MODE_LOAD;
      it.addr = AddrWidth'(addr);
      it.word = word;
      return it;
   endfunction

   function automatic pos_item_type absorb_item(input int sq, input logic [2:0] piece,
                                                input bit black);
      pos_item_type it;
      it = '0;
      it.mode   = MODE_ABSORB;
      it.square = SquareWidth'(sq);
      it.piece  = piece;
      it.black  = black;
      return it;
   endfunction

   function automatic pos_item_type finish_item(input bit white_moves, input bit ep_valid,
                                                input int ep_sq, input int castling,
                                                input int fullmove, input int halfmove);
      pos_item_type it;
      it = '0;
      it.mode        = MODE_FINISH;
      it.white_moves = white_moves;
      it.ep_valid    = ep_valid;
      it.ep_square   = SquareWidth'(ep_sq);
      it.castling    = CastleBits'(castling);
      it.fullmove    = MoveWidth'(fullmove);
      it.halfmove    = MoveWidth'(halfmove);
      return it;
   endfunction

   task automatic add_row(input pos_item_type it, input bit typed,
                          input logic [KeyWidth-1:0] hash, input cfg_set_type cfg);
      script_row_type row;
      row.item  = it;
      row.typed = typed;
      row.hash  = hash;
      row.cfg   = cfg;
      script.push_back(row);
   endtask

   // hash predictor: updates tables and accumulator, returns 1 when a hash is emitted
   function automatic bit predict_hash(input pos_item_type it, output logic [KeyWidth-1:0] h);
      int kind;
      int ep_idx;
      h = '0;
      case (it.mode)
         MODE_LOAD: begin
            if (it.addr < PieceWords) begin
               key_table[it.addr] = it.word;
               words_loaded++;
               if (!piece_loaded[it.addr]) begin
                  piece_loaded[it.addr] = 1'b1;
                  piece_loaded_list.push_back(int'(it.addr));
               end
            end else if (it.addr < AllWords) begin
               ep_idx = int'(it.addr) - PieceWords;
               ep_table[ep_idx] = it.word;
               words_loaded++;
               if (!ep_loaded[ep_idx]) begin
                  ep_loaded[ep_idx] = 1'b1;
                  ep_loaded_list.push_back(ep_idx);
               end
            end
            return 1'b0;
         end
         MODE_ABSORB: begin
            if (it.piece != PIECE_NONE && it.piece != PIECE_BAD) begin
               kind = int'(it.piece) - 1 + (it.black ? KindHalf : 0);
               running_hash ^= key_table[int'(it.square) * PieceKinds + kind];
            end
            return 1'b0;
         end
         MODE_FINISH: begin
            h = running_hash;
            if (it.white_moves) h ^= side_key_reg;
            if (it.ep_valid) h ^= ep_table[it.ep_square];
            h ^= {{(KeyWidth-MoveWidth){1'b0}}, it.fullmove} * full_coeff;
            h ^= {{(KeyWidth-MoveWidth){1'b0}}, it.halfmove} * half_coeff;
            for (int b = 0; b < CastleBits; b++)
               if (it.castling[b]) h ^= castle_key[b];
            running_hash = '0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [CsrIndexWidth-1:0] csr_of(input int i);
      case (i)
         0: return CSR_SIDE_KEY;
         1: return CSR_FULLMOVE_COEFF;
         2: return CSR_HALFMOVE_COEFF;
         3: return CSR_CASTLE_KEY_A;
         4: return CSR_CASTLE_KEY_B;
         5: return CSR_CASTLE_KEY_C;
         default: return CSR_CASTLE_KEY_D;
      endcase
   endfunction

   function automatic logic [KeyWidth-1:0] config_word(input cfg_set_type s,
                                                       input logic [CsrIndexWidth-1:0] idx);
      case (s)
         CFG_RESET_VALUES: return '0;
         CFG_ALL_ONES: return '1;
         CFG_UNIT_COEFF:
            if (idx == CSR_FULLMOVE_COEFF || idx == CSR_HALFMOVE_COEFF) return 64'd1;
            else return rand_word();
         default: return rand_word();
      endcase
   endfunction

   // write all seven registers back to back, valid held high across them
   task automatic apply_config(input cfg_set_type s);
      logic [CsrIndexWidth-1:0] idx;
      logic [KeyWidth-1:0] v;
      for (int i = 0; i < CSR_COUNT; i++) begin
         idx = csr_of(i);
         v = config_word(s, idx);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= v;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx)
            CSR_SIDE_KEY:       side_key_reg = v;
            CSR_FULLMOVE_COEFF: full_coeff = v;
            CSR_HALFMOVE_COEFF: half_coeff = v;
            CSR_CASTLE_KEY_A:   castle_key[0] = v;
            CSR_CASTLE_KEY_B:   castle_key[1] = v;
            CSR_CASTLE_KEY_C:   castle_key[2] = v;
            default:            castle_key[3] = v;
         endcase
      end
      csr_valid <= 1'b0;
      current_cfg = s;
   endtask

   // offer one item, with optional idle gap first; predicts on acceptance
   task automatic send_item(input pos_item_type it, input bit typed,
                            input logic [KeyWidth-1:0] typed_hash);
      logic [KeyWidth-1:0] h;
      if (calm_items != 0) calm_items--;
      else if ($urandom_range(39) == 0) calm_items = 25;
      if (calm_items == 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_mode          <= it.mode;
      req_table_address <= it.addr;
      req_table_word    <= it.word;
      req_square        <= it.square;
      req_piece_type    <= it.piece;
      req_piece_black   <= it.black;
      req_white_to_move <= it.white_moves;
      req_ep_valid      <= it.ep_valid;
      req_ep_square     <= it.ep_square;
      req_castling      <= it.castling;
      req_fullmove      <= it.fullmove;
      req_halfmove      <= it.halfmove;
      @(posedge clock);
      while (req_stall) begin
         input_stall_cycles++;
         @(posedge clock);
      end
      items_taken++;
      if (predict_hash(it, h)) pending_hashes.push_back(typed ? typed_hash : h);
   endtask

   // wait for every pending hash, then let in-flight loads and absorbs retire
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_hashes.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_hashes.size() != 0) begin
         flag_mismatch($sformatf("%0d hashes never arrived, oldest", pending_hashes.size()),
                       pending_hashes[0], 'x);
         pending_hashes.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random positions: a few key loads, a run of absorbs, then a finish
   task automatic run_positions(input int target);
      pos_item_type it;
      int useful;
      int n_loads;
      int n_abs;
      int a;
      int k;
      useful = 0;
      while (useful < target) begin
         n_loads = ($urandom_range(9) < 3 || piece_loaded_list.size() < 8)
                   ? $urandom_range(1, 4) : 0;
         for (int i = 0; i < n_loads; i++) begin
            it = rand_item();
            it.mode = MODE_LOAD;
            if ($urandom_range(11) == 0) it.addr = AddrWidth'($urandom_range(AllWords, 1023));
            else if ($urandom_range(5) == 0)
               it.addr = AddrWidth'($urandom_range(PieceWords, AllWords - 1));
            else it.addr = AddrWidth'($urandom_range(PieceWords - 1));
            send_item(it, 1'b0, '0);
            if (it.addr < AllWords) useful++;
         end
         n_abs = $urandom_range(10);
         for (int i = 0; i < n_abs; i++) begin
            it = rand_item();
            if ($urandom_range(9) == 0) begin
               // ignored items: unused mode or an empty/invalid piece kind
               if ($urandom_range(1)) it.mode = MODE_UNUSED;
               else begin
                  it.mode = MODE_ABSORB;
                  it.piece = $urandom_range(1) ? PIECE_NONE : PIECE_BAD;
               end
               send_item(it, 1'b0, '0);
            end else if (piece_loaded_list.size() != 0) begin
               a = piece_loaded_list[$urandom_range(piece_loaded_list.size() - 1)];
               k = a % PieceKinds;
               it.mode   = MODE_ABSORB;
               it.square = SquareWidth'(a / PieceKinds);
               it.black  = (k >= KindHalf);
               it.piece  = 3'(k % KindHalf + 1);
               send_item(it, 1'b0, '0);
               useful++;
            end
         end
         it = rand_item();
         it.mode = MODE_FINISH;
         it.ep_valid = (ep_loaded_list.size() != 0) && ($urandom_range(1) == 1);
         if (it.ep_valid)
            it.ep_square = SquareWidth'(ep_loaded_list[$urandom_range(ep_loaded_list.size() - 1)]);
         send_item(it, 1'b0, '0);
         useful++;
      end
   endtask

   // long receiver hold-off, armed once by the stimulus
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result side: check each accepted hash, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         calm_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            hashes_seen++;
            if (pending_hashes.size() == 0) begin
               flag_mismatch("hash with none pending", 'x, rsp_hash_value);
            end else begin
               oldest_hash = pending_hashes.pop_front();
               if (rsp_hash_value !== oldest_hash)
                  flag_mismatch("hash_value", oldest_hash, rsp_hash_value);
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
         end else if (calm_left != 0) begin
            rsp_stall <= 1'b0;
            calm_left <= calm_left - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
            if ($urandom_range(63) == 0) calm_left <= 30;
         end
      end
   end

   // stimulus
   initial begin
      for (int b = 0; b < CastleBits; b++) castle_key[b] = '0;

      // at reset values every register is zero, so only table keys show up
      add_row(finish_item(1, 0, 0, 15, 16'hffff, 16'hffff), 1, '0, CFG_RESET_VALUES);
      add_row(load_item(0, KEY_X), 0, '0, CFG_RESET_VALUES);
      add_row(load_item(PieceWords - 1, KEY_ONES), 0, '0, CFG_RESET_VALUES);
      add_row(load_item(PieceWords, KEY_Y), 0, '0, CFG_RESET_VALUES);
      add_row(load_item(AllWords - 1, KEY_Z), 0, '0, CFG_RESET_VALUES);
      // out-of-range load addresses are dropped
      add_row(load_item(AllWords, KEY_ONES), 0, '0, CFG_RESET_VALUES);
      add_row(load_item(1023, KEY_ONES), 0, '0, CFG_RESET_VALUES);
      add_row(absorb_item(0, PIECE_PAWN, 0), 0, '0, CFG_RESET_VALUES);
      add_row(finish_item(0, 0, 63, 5, 1, 2), 1, KEY_X, CFG_RESET_VALUES);
      add_row(absorb_item(63, PIECE_KING, 1), 0, '0, CFG_RESET_VALUES);
      // empty and invalid piece kinds, and the unused mode, change nothing
      add_row(absorb_item(5, PIECE_NONE, 0), 0, '0, CFG_RESET_VALUES);
      add_row(absorb_item(63, PIECE_BAD, 1), 0, '0, CFG_RESET_VALUES);
      add_row(rand_item(), 0, '0, CFG_RESET_VALUES);
      script[$].item.mode = MODE_UNUSED;
      add_row(finish_item(1, 1, 63, 10, 100, 7), 1, KEY_ONES ^ KEY_Z, CFG_RESET_VALUES);
      // the same key absorbed twice cancels
      add_row(absorb_item(0, PIECE_PAWN, 0), 0, '0, CFG_RESET_VALUES);
      add_row(absorb_item(0, PIECE_PAWN, 0), 0, '0, CFG_RESET_VALUES);
      add_row(finish_item(0, 1, 0, 0, 0, 0), 1, KEY_Y, CFG_RESET_VALUES);
      // all registers at all ones
      add_row(finish_item(1, 0, 0, 0, 0, 0), 1, KEY_ONES, CFG_ALL_ONES);
      add_row(finish_item(0, 0, 0, 15, 0, 0), 1, '0, CFG_ALL_ONES);
      add_row(finish_item(0, 0, 0, 1, 1, 0), 1, '0, CFG_ALL_ONES);
      add_row(finish_item(0, 0, 0, 0, 16'hffff, 0), 0, '0, CFG_ALL_ONES);
      add_row(finish_item(0, 0, 0, 0, 0, 16'hffff), 0, '0, CFG_ALL_ONES);
      add_row(absorb_item(63, PIECE_KING, 1), 0, '0, CFG_ALL_ONES);
      add_row(finish_item(1, 1, 63, 10, 16'h1234, 16'h8000), 0, '0, CFG_ALL_ONES);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].cfg != current_cfg) begin
            settle();
            apply_config(script[i].cfg);
         end
         send_item(script[i].item, script[i].typed, script[i].hash);
      end

      // random phases, each with its own register setting and idle pattern
      for (int p = 0; p < 4; p++) begin
         settle();
         case (p)
            0: begin
               apply_config(CFG_RANDOM);
               send_idle_pct = 0;
               stall_pct <= 0;
               hold_wanted <= 1'b1;
            end
            1: begin
               apply_config(CFG_ALL_ONES);
               send_idle_pct = 79;
               stall_pct <= 0;
            end
            2: begin
               apply_config(CFG_UNIT_COEFF);
               send_idle_pct = 0;
               stall_pct <= 79;
            end
            default: begin
               apply_config(CFG_RANDOM);
               send_idle_pct = 28;
               stall_pct <= 28;
            end
         endcase
         run_positions(PHASE_ITEMS);
      end
      settle();

      $display("covered %0d items, %0d key words loaded, %0d hashes compared",
               items_taken, words_loaded, hashes_seen);
      $display("input held back %0d cycles across four idle patterns and four register sets",
               input_stall_cycles);
      if (hash_errors == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

endmodule
